// ===== hw/rtl/tmep_pkg.sv =====
// Shared types and constants for the text markup escape parser.
package tmep_pkg;

   // Input word: one message byte and its end-of-message flag.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_message;
   } tmep_req_type;

   // Result word: one glyph with the attributes in force.
   typedef struct packed {
      logic [7:0] glyph_code;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] font_select;
      logic [3:0] wave_frequency;
      logic [3:0] gradient_select;
      logic       message_done;
   } tmep_rsp_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FONT_COUNT     = 2'd0;
   localparam logic [1:0] CSR_GRADIENT_COUNT = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_CODE    = 2'd2;

   // Configuration reset values.
   localparam logic [3:0] FONT_COUNT_RESET     = 4'd1;
   localparam logic [3:0] GRADIENT_COUNT_RESET = 4'd0;
   localparam logic [7:0] ESCAPE_CODE_RESET    = 8'd27;

   // Default color level at the start of a message.
   localparam logic [7:0] COLOR_DEFAULT = 8'h80;

   // Characters the parser recognizes.
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_C     = 8'h43;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;
   localparam logic [7:0] HEX_OFFSET = 8'd10;

endpackage

// ===== hw/rtl/text_markup_escape_parser.sv =====
// Top level of the text markup escape parser.
//
// Message bytes enter on the req_ channel, one per word, each with an
// end-of-message flag. Display text leaves on the rsp_ channel as one word
// per glyph, carrying the color, font, sine frequency and gradient that are
// in force. Escape sequences (escape byte, then C with hex pairs, F, S or G
// with a digit) change the attributes and produce no word.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The csr_ port writes font_count, gradient_count and
// escape_code; write only while the block is idle.
// A byte goes from the input register to the output register on its way to
// rsp_. One byte is taken every cycle while req_stall is low; the input
// register is decoded against the parse state into the output register.
// While rsp_stall holds a glyph, one further byte waits in the input
// register, and req_stall rises only if that byte would produce a glyph.
// Reset (synchronous) empties both registers, restores the configuration
// defaults and the default attributes. Attributes also return to gray 0x80,
// font 0, sine 0 and no gradient after the final byte of every message.
module text_markup_escape_parser
   import tmep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  tmep_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output tmep_rsp_type rsp_data,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_data
);

   typedef enum logic [3:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_RED_HI,
      PH_RED_LO,
      PH_GRN_HI,
      PH_GRN_LO,
      PH_BLU_HI,
      PH_BLU_LO,
      PH_FONT,
      PH_SINE,
      PH_GRAD
   } phase_type;

   // Configuration registers.
   logic [3:0]   font_count_ff;
   logic [3:0]   gradient_count_ff;
   logic [7:0]   escape_code_ff;

   // Input register.
   logic         in_valid_ff;
   tmep_req_type in_data_ff;

   // Parse state.
   phase_type    phase_ff, phase_in;
   logic [3:0]   hold_ff, hold_in;
   logic [7:0]   red_ff, red_in;
   logic [7:0]   green_ff, green_in;
   logic [7:0]   blue_ff, blue_in;
   logic [3:0]   font_ff, font_in;
   logic [3:0]   wave_ff, wave_in;
   logic [3:0]   gradient_ff, gradient_in;

   // Output register.
   logic         rsp_valid_ff;
   tmep_rsp_type rsp_data_ff;

   logic         as_text;
   logic         emit;
   logic         out_free;
   logic         advance;
   logic         is_digit;
   logic [3:0]   digit;
   logic [7:0]   upper_byte;
   logic [7:0]   hex_sum;
   logic [3:0]   nibble;
   logic [7:0]   byte_val;
   logic         last;

   assign byte_val = in_data_ff.text_byte;
   assign last     = in_data_ff.end_of_message;

   // Character classification and hex nibble value.
   always_comb begin
      is_digit   = (byte_val >= CHAR_0) && (byte_val <= CHAR_9);
      digit      = 4'(byte_val - CHAR_0);
      upper_byte = byte_val;
      if ((byte_val >= CHAR_LOW_A) && (byte_val <= CHAR_LOW_Z)) begin
         upper_byte = byte_val - CASE_SHIFT;
      end
      hex_sum = upper_byte + HEX_OFFSET - CHAR_A;
      nibble  = is_digit ? digit : hex_sum[3:0];
   end

   // Next parse state for the byte in the input register.
   always_comb begin
      phase_in    = phase_ff;
      hold_in     = hold_ff;
      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      font_in     = font_ff;
      wave_in     = wave_ff;
      gradient_in = gradient_ff;
      as_text     = 1'b0;

      unique case (phase_ff)
         PH_ESCAPE: begin
            priority if (byte_val == CHAR_C) begin
               phase_in = PH_RED_HI;
            end else if (byte_val == CHAR_F) begin
               phase_in = PH_FONT;
            end else if (byte_val == CHAR_S) begin
               phase_in = PH_SINE;
            end else if (byte_val == CHAR_G) begin
               phase_in = PH_GRAD;
            end else begin
               phase_in = PH_NORMAL;
            end
         end
         PH_RED_HI, PH_GRN_HI, PH_BLU_HI: begin
            if (last) begin
               as_text = 1'b1;
            end else begin
               hold_in  = nibble;
               phase_in = phase_type'(phase_ff + 4'd1);
            end
         end
         PH_RED_LO: begin
            red_in   = {hold_ff, nibble};
            phase_in = PH_GRN_HI;
         end
         PH_GRN_LO: begin
            green_in = {hold_ff, nibble};
            phase_in = PH_BLU_HI;
         end
         PH_BLU_LO: begin
            blue_in  = {hold_ff, nibble};
            phase_in = PH_NORMAL;
         end
         PH_FONT, PH_SINE, PH_GRAD: begin
            if (!is_digit) begin
               as_text = 1'b1;
            end else begin
               if (phase_ff == PH_FONT) begin
                  if (digit < font_count_ff) begin
                     font_in = digit;
                  end
               end else if (phase_ff == PH_SINE) begin
                  wave_in = digit;
               end else begin
                  if (digit <= gradient_count_ff) begin
                     gradient_in = digit;
                  end
               end
               phase_in = PH_NORMAL;
            end
         end
         default: begin
            as_text = 1'b1;
         end
      endcase

      // Text bytes either start an escape or become a glyph.
      emit = 1'b0;
      if (as_text) begin
         if (byte_val == escape_code_ff) begin
            phase_in = PH_ESCAPE;
         end else begin
            phase_in = PH_NORMAL;
            emit     = 1'b1;
         end
      end

      // Every message starts from the default attributes.
      if (last) begin
         phase_in    = PH_NORMAL;
         hold_in     = 4'd0;
         red_in      = COLOR_DEFAULT;
         green_in    = COLOR_DEFAULT;
         blue_in     = COLOR_DEFAULT;
         font_in     = 4'd0;
         wave_in     = 4'd0;
         gradient_in = 4'd0;
      end
   end

   // Handshake: the held byte moves on unless its glyph has nowhere to go.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         font_count_ff     <= FONT_COUNT_RESET;
         gradient_count_ff <= GRADIENT_COUNT_RESET;
         escape_code_ff    <= ESCAPE_CODE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FONT_COUNT:     font_count_ff     <= csr_data[3:0];
            CSR_GRADIENT_COUNT: gradient_count_ff <= csr_data[3:0];
            CSR_ESCAPE_CODE:    escape_code_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Parse state update as each byte leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_NORMAL;
         hold_ff     <= 4'd0;
         red_ff      <= COLOR_DEFAULT;
         green_ff    <= COLOR_DEFAULT;
         blue_ff     <= COLOR_DEFAULT;
         font_ff     <= 4'd0;
         wave_ff     <= 4'd0;
         gradient_ff <= 4'd0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         hold_ff     <= hold_in;
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         font_ff     <= font_in;
         wave_ff     <= wave_in;
         gradient_ff <= gradient_in;
      end
   end

   // Output register; glyphs carry the attributes before this byte's update.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff.glyph_code      <= byte_val;
         rsp_data_ff.red             <= red_ff;
         rsp_data_ff.green           <= green_ff;
         rsp_data_ff.blue            <= blue_ff;
         rsp_data_ff.font_select     <= font_ff;
         rsp_data_ff.wave_frequency  <= wave_ff;
         rsp_data_ff.gradient_select <= gradient_ff;
         rsp_data_ff.message_done    <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
